// ----- design/ili_pkg.sv -----
// ----------------------------------------------------------------------------
// ili_pkg
// Shared constants, codes and types of the indexed list block.
// ----------------------------------------------------------------------------
package ili_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [2:0] ACT_READ    = 3'd0;
   localparam logic [2:0] ACT_INS_HD  = 3'd1;
   localparam logic [2:0] ACT_INS_TL  = 3'd2;
   localparam logic [2:0] ACT_INS_POS = 3'd3;
   localparam logic [2:0] ACT_DELETE  = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;

   typedef logic [31:0] word_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] pos;
      word_type         value;
   } shift_cmd_type;

endpackage

// ----- design/ili_cell.sv -----
// ----------------------------------------------------------------------------
// ili_cell
// One storage slot of the list; takes its left or right neighbor, or the new value, on a shift.
// ----------------------------------------------------------------------------
module ili_cell (
   input  logic                        clock,
   input  ili_pkg::shift_cmd_type      cmd,
   input  logic [ili_pkg::IDX_W-1:0]   cell_idx,
   input  ili_pkg::word_type           left_value,
   input  ili_pkg::word_type           right_value,
   output ili_pkg::word_type           value
);
   import ili_pkg::*;

   word_type value_ff;
   word_type value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (cell_idx == cmd.pos) begin
            value_in = cmd.value;
         end else if (cell_idx > cmd.pos) begin
            value_in = left_value;
         end
      end else if (cmd.del) begin
         if (cell_idx >= cmd.pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- design/ili_ctrl.sv -----
// ----------------------------------------------------------------------------
// ili_ctrl
// Request decode, length count, read select and response register.
// ----------------------------------------------------------------------------
module ili_ctrl (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_valid,
   output logic                                            req_stall,
   input  logic [2:0]                                      req_action,
   input  logic [7:0]                                      req_position,
   input  logic signed [31:0]                              req_item_value,
   output logic                                            rsp_valid,
   input  logic                                            rsp_stall,
   output logic [1:0]                                      rsp_status,
   output logic signed [31:0]                              rsp_read_value,
   output logic [4:0]                                      rsp_length,
   input  logic [ili_pkg::CAPACITY-1:0][31:0]              cell_values,
   output ili_pkg::shift_cmd_type                          cmd
);
   import ili_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   word_type         rdval_ff, rdval_in;
   logic [4:0]       length_ff, length_in;

   logic             accept;
   logic [CMP_W-1:0] pos_ext, cnt_ext;
   logic             full;
   logic             ins_ok, del_ok;
   logic [IDX_W-1:0] shift_pos;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_ext = {{(CMP_W-POS_W){1'b0}}, req_position};
   assign cnt_ext = {{(CMP_W-CNT_W){1'b0}}, count_ff};
   assign full    = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      status_in = ST_DONE;
      rdval_in  = NO_VALUE;
      ins_ok    = 1'b0;
      del_ok    = 1'b0;
      shift_pos = req_position[IDX_W-1:0];
      case (req_action)
         ACT_READ: begin
            if (pos_ext < cnt_ext) begin
               rdval_in = cell_values[req_position[IDX_W-1:0]];
            end else begin
               status_in = ST_RANGE;
            end
         end
         ACT_INS_HD: begin
            shift_pos = '0;
            if (full) status_in = ST_FULL;
            else      ins_ok = 1'b1;
         end
         ACT_INS_TL: begin
            shift_pos = count_ff[IDX_W-1:0];
            if (full) status_in = ST_FULL;
            else      ins_ok = 1'b1;
         end
         ACT_INS_POS: begin
            if (pos_ext > cnt_ext) status_in = ST_RANGE;
            else if (full)         status_in = ST_FULL;
            else                   ins_ok = 1'b1;
         end
         ACT_DELETE: begin
            if (pos_ext >= cnt_ext) status_in = ST_RANGE;
            else                    del_ok = 1'b1;
         end
         default: begin
            status_in = ST_RANGE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept && ins_ok) count_in = count_ff + CNT_W'(1);
      if (accept && del_ok) count_in = count_ff - CNT_W'(1);
   end

   assign length_in    = count_in[4:0];
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);

   assign cmd.ins   = accept && ins_ok;
   assign cmd.del   = accept && del_ok;
   assign cmd.pos   = shift_pos;
   assign cmd.value = req_item_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rdval_ff  <= rdval_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_length     = length_ff;

endmodule

// ----- design/indexed_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit values with read, insert and delete by index.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item: action, position and item_value. Each
//   item returns exactly one rsp_ item with status, read_value and the new
//   length, in order.
//   The list lives in a row of cells, one value each. An insert or delete
//   makes the cells behind the position all take a neighbor's value, and the
//   cell at it the new item (insert) or its right neighbor (delete).
//   rsp_valid rises in the cycle after a request is accepted.
//   Throughput: one item per cycle while rsp_stall stays low.
//   When the receiver stalls, the response register holds its item and
//   req_stall rises until it is taken; no request is lost.
//   Reset clears the length to zero and drops any pending response; cell
//   contents are not cleared, since only entries below the length are read.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_item_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [4:0]         rsp_length
);
   import ili_pkg::*;

   logic [CAPACITY-1:0][31:0] cell_values;
   shift_cmd_type             cmd;

   ili_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_length),
      .cell_values    (cell_values),
      .cmd            (cmd)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_v, right_v;

      // ends of the row feed back their own value, which is harmless there
      if (i == 0) begin : g_first
         assign left_v = cell_values[i];
      end else begin : g_mid_l
         assign left_v = cell_values[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_values[i];
      end else begin : g_mid_r
         assign right_v = cell_values[i+1];
      end

      ili_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (IDX_W'(i)),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_values[i])
      );
   end

endmodule
